// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the deframer modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with explicit clock and reset.
`define SPD_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion on the block's clock and reset.
`define SPD_ASSERT(label, prop, msg) \
   `SPD_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// ===== design/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg
// Types and constants of the spectrum packet deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

   typedef enum logic [1:0] {
      PH_SYNC,
      PH_HEADER,
      PH_BODY,
      PH_TAIL
   } phase_type;

   localparam logic [7:0] SYNC_FIRST  = 8'h5A;
   localparam logic [7:0] SYNC_SECOND = 8'hA5;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [1:0] KIND_BIN     = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_BAD_SUM = 2'd2;
   localparam logic [1:0] KIND_TIMEOUT = 2'd3;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_EXPECTED_SIZE  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SYNC_WINDOW    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HEADER_TIMEOUT = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BODY_TIMEOUT   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TAIL_TIMEOUT   = 3'd4;

   localparam logic [15:0] RST_EXPECTED_SIZE  = 16'd256;
   localparam logic [15:0] RST_SYNC_WINDOW    = 16'd2000;
   localparam logic [15:0] RST_HEADER_TIMEOUT = 16'd20;
   localparam logic [15:0] RST_BODY_TIMEOUT   = 16'd100;
   localparam logic [15:0] RST_TAIL_TIMEOUT   = 16'd20;

   localparam logic [3:0] HEADER_LAST_BYTE = 4'd9;
   localparam logic [3:0] BIN_LAST_BYTE    = 4'd5;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [15:0]        bin_index;
      logic signed [15:0] bin_real;
      logic signed [15:0] bin_imag;
      logic               index_in_range;
      logic [15:0]        sequence_res;
      logic [15:0]        bins_in_packet;
      logic [31:0]        energy_bits;
   } rsp_type;

   typedef struct packed {
      logic [15:0] expected_size;
      logic [15:0] sync_window_ticks;
      logic [15:0] header_timeout_ticks;
      logic [15:0] body_timeout_ticks;
      logic [15:0] tail_timeout_ticks;
   } cfg_type;

endpackage

// ===== design/spd_csr.sv =====
// ----------------------------------------------------------------------------
// spd_csr
// Configuration registers, written through the csr word channel.
// ----------------------------------------------------------------------------
module spd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [spd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0]                         csr_data,
   output spd_pkg::cfg_type                    cfg
);

   spd_pkg::cfg_type cfg_ff;
   spd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            spd_pkg::REG_EXPECTED_SIZE:  cfg_in.expected_size        = csr_data;
            spd_pkg::REG_SYNC_WINDOW:    cfg_in.sync_window_ticks    = csr_data;
            spd_pkg::REG_HEADER_TIMEOUT: cfg_in.header_timeout_ticks = csr_data;
            spd_pkg::REG_BODY_TIMEOUT:   cfg_in.body_timeout_ticks   = csr_data;
            spd_pkg::REG_TAIL_TIMEOUT:   cfg_in.tail_timeout_ticks   = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_size        <= spd_pkg::RST_EXPECTED_SIZE;
         cfg_ff.sync_window_ticks    <= spd_pkg::RST_SYNC_WINDOW;
         cfg_ff.header_timeout_ticks <= spd_pkg::RST_HEADER_TIMEOUT;
         cfg_ff.body_timeout_ticks   <= spd_pkg::RST_BODY_TIMEOUT;
         cfg_ff.tail_timeout_ticks   <= spd_pkg::RST_TAIL_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/spd_core.sv =====
// ----------------------------------------------------------------------------
// spd_core
// Framing state machine: sync hunt, header capture and check, bin assembly,
// checksum tail and phase timers. One word is consumed per accepted cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spd_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  spd_pkg::req_type req_data,
   input  spd_pkg::cfg_type cfg,
   output logic             res_valid,
   output spd_pkg::rsp_type res_data
);

   spd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  prev_byte_ff, prev_byte_in;
   logic [3:0]  byte_cnt_ff, byte_cnt_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [15:0] size_ff, size_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] seq_ff, seq_in;
   logic [31:0] energy_ff, energy_in;
   logic [7:0]  csum_ff, csum_in;
   logic [39:0] asm_ff, asm_in;
   logic [7:0]  tail_lo_ff, tail_lo_in;
   logic [15:0] bins_done_ff, bins_done_in;

   logic        tick;
   logic [7:0]  rx;
   logic [15:0] half_size;
   logic [31:0] energy_full;
   logic        hdr_ok;
   logic [15:0] bins_next;
   logic [15:0] bin_idx;
   logic        body_expired;
   logic        tail_expired;

   assign tick         = (req_data.command == spd_pkg::CMD_TICK);
   assign rx           = req_data.rx_byte;
   assign half_size    = cfg.expected_size >> 1;
   // last header byte is the top byte of the energy word
   assign energy_full  = {rx, energy_ff[23:0]};
   assign hdr_ok       = (size_ff == cfg.expected_size) && (count_ff != 16'd0) &&
                         (count_ff < half_size) && (energy_full[30:23] != 8'hFF) &&
                         !(energy_full[31] && (energy_full[30:0] != 31'd0));
   assign bins_next    = bins_done_ff + 16'd1;
   assign bin_idx      = asm_ff[15:0];
   assign body_expired = (elapsed_ff >= cfg.body_timeout_ticks);
   assign tail_expired = (elapsed_ff >= cfg.tail_timeout_ticks);

   // next state
   always_comb begin
      phase_in     = phase_ff;
      prev_byte_in = prev_byte_ff;
      byte_cnt_in  = byte_cnt_ff;
      elapsed_in   = elapsed_ff;
      size_in      = size_ff;
      count_in     = count_ff;
      seq_in       = seq_ff;
      energy_in    = energy_ff;
      csum_in      = csum_ff;
      asm_in       = asm_ff;
      tail_lo_in   = tail_lo_ff;
      bins_done_in = bins_done_ff;
      if (fire) begin
         if (tick) begin
            unique case (phase_ff)
               spd_pkg::PH_SYNC: begin
                  if (({1'b0, elapsed_ff} + 17'd1) >= {1'b0, cfg.sync_window_ticks}) begin
                     prev_byte_in = 8'd0;
                     elapsed_in   = 16'd0;
                  end else begin
                     elapsed_in = elapsed_ff + 16'd1;
                  end
               end
               spd_pkg::PH_HEADER: begin
                  if (elapsed_ff >= cfg.header_timeout_ticks) begin
                     phase_in     = spd_pkg::PH_SYNC;
                     prev_byte_in = 8'd0;
                     byte_cnt_in  = 4'd0;
                     elapsed_in   = 16'd0;
                  end else begin
                     elapsed_in = elapsed_ff + 16'd1;
                  end
               end
               spd_pkg::PH_BODY: begin
                  if (body_expired) begin
                     phase_in     = spd_pkg::PH_SYNC;
                     prev_byte_in = 8'd0;
                     byte_cnt_in  = 4'd0;
                     elapsed_in   = 16'd0;
                  end else begin
                     elapsed_in = elapsed_ff + 16'd1;
                  end
               end
               spd_pkg::PH_TAIL: begin
                  if (tail_expired) begin
                     phase_in     = spd_pkg::PH_SYNC;
                     prev_byte_in = 8'd0;
                     byte_cnt_in  = 4'd0;
                     elapsed_in   = 16'd0;
                  end else begin
                     elapsed_in = elapsed_ff + 16'd1;
                  end
               end
               default: phase_in = spd_pkg::PH_SYNC;
            endcase
         end else begin
            unique case (phase_ff)
               spd_pkg::PH_SYNC: begin
                  if (prev_byte_ff == spd_pkg::SYNC_FIRST && rx == spd_pkg::SYNC_SECOND) begin
                     phase_in    = spd_pkg::PH_HEADER;
                     byte_cnt_in = 4'd0;
                     elapsed_in  = 16'd0;
                     csum_in     = spd_pkg::SYNC_FIRST ^ spd_pkg::SYNC_SECOND;
                     size_in     = 16'd0;
                     count_in    = 16'd0;
                     seq_in      = 16'd0;
                     energy_in   = 32'd0;
                  end else begin
                     prev_byte_in = rx;
                  end
               end
               spd_pkg::PH_HEADER: begin
                  csum_in     = csum_ff ^ rx;
                  byte_cnt_in = byte_cnt_ff + 4'd1;
                  case (byte_cnt_ff)
                     4'd0:    size_in[7:0]     = rx;
                     4'd1:    size_in[15:8]    = rx;
                     4'd2:    count_in[7:0]    = rx;
                     4'd3:    count_in[15:8]   = rx;
                     4'd4:    seq_in[7:0]      = rx;
                     4'd5:    seq_in[15:8]     = rx;
                     4'd6:    energy_in[7:0]   = rx;
                     4'd7:    energy_in[15:8]  = rx;
                     4'd8:    energy_in[23:16] = rx;
                     default: energy_in[31:24] = rx;
                  endcase
                  if (byte_cnt_ff == spd_pkg::HEADER_LAST_BYTE) begin
                     byte_cnt_in = 4'd0;
                     elapsed_in  = 16'd0;
                     if (hdr_ok) begin
                        phase_in     = spd_pkg::PH_BODY;
                        bins_done_in = 16'd0;
                        asm_in       = 40'd0;
                     end else begin
                        phase_in     = spd_pkg::PH_SYNC;
                        prev_byte_in = 8'd0;
                     end
                  end
               end
               spd_pkg::PH_BODY: begin
                  csum_in = csum_ff ^ rx;
                  if (byte_cnt_ff != spd_pkg::BIN_LAST_BYTE) begin
                     byte_cnt_in = byte_cnt_ff + 4'd1;
                     case (byte_cnt_ff)
                        4'd0:    asm_in[7:0]   = rx;
                        4'd1:    asm_in[15:8]  = rx;
                        4'd2:    asm_in[23:16] = rx;
                        4'd3:    asm_in[31:24] = rx;
                        default: asm_in[39:32] = rx;
                     endcase
                  end else begin
                     byte_cnt_in  = 4'd0;
                     asm_in       = 40'd0;
                     bins_done_in = bins_next;
                     if (bins_next >= count_ff) begin
                        phase_in   = spd_pkg::PH_TAIL;
                        elapsed_in = 16'd0;
                     end
                  end
               end
               spd_pkg::PH_TAIL: begin
                  if (byte_cnt_ff == 4'd0) begin
                     tail_lo_in  = rx;
                     byte_cnt_in = 4'd1;
                  end else begin
                     phase_in     = spd_pkg::PH_SYNC;
                     prev_byte_in = 8'd0;
                     byte_cnt_in  = 4'd0;
                     elapsed_in   = 16'd0;
                  end
               end
               default: phase_in = spd_pkg::PH_SYNC;
            endcase
         end
      end
   end

   // result
   always_comb begin
      res_valid               = 1'b0;
      res_data.kind           = spd_pkg::KIND_BIN;
      res_data.bin_index      = 16'd0;
      res_data.bin_real       = 16'sd0;
      res_data.bin_imag       = 16'sd0;
      res_data.index_in_range = 1'b0;
      res_data.sequence_res   = seq_ff;
      res_data.bins_in_packet = count_ff;
      res_data.energy_bits    = energy_ff;
      if (fire) begin
         if (tick) begin
            if ((phase_ff == spd_pkg::PH_BODY && body_expired) ||
                (phase_ff == spd_pkg::PH_TAIL && tail_expired)) begin
               res_valid     = 1'b1;
               res_data.kind = spd_pkg::KIND_TIMEOUT;
            end
         end else if (phase_ff == spd_pkg::PH_BODY && byte_cnt_ff == spd_pkg::BIN_LAST_BYTE) begin
            res_valid               = 1'b1;
            res_data.kind           = spd_pkg::KIND_BIN;
            res_data.bin_index      = bin_idx;
            res_data.bin_real       = $signed(asm_ff[31:16]);
            res_data.bin_imag       = $signed({rx, asm_ff[39:32]});
            res_data.index_in_range = (bin_idx != 16'd0) && (bin_idx < half_size);
         end else if (phase_ff == spd_pkg::PH_TAIL && byte_cnt_ff != 4'd0) begin
            res_valid     = 1'b1;
            res_data.kind = (tail_lo_ff == csum_ff && rx == 8'd0) ?
                            spd_pkg::KIND_GOOD : spd_pkg::KIND_BAD_SUM;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= spd_pkg::PH_SYNC;
         prev_byte_ff <= 8'd0;
         byte_cnt_ff  <= 4'd0;
         elapsed_ff   <= 16'd0;
         bins_done_ff <= 16'd0;
         csum_ff      <= 8'd0;
      end else begin
         phase_ff     <= phase_in;
         prev_byte_ff <= prev_byte_in;
         byte_cnt_ff  <= byte_cnt_in;
         elapsed_ff   <= elapsed_in;
         bins_done_ff <= bins_done_in;
         csum_ff      <= csum_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff    <= size_in;
      count_ff   <= count_in;
      seq_ff     <= seq_in;
      energy_ff  <= energy_in;
      asm_ff     <= asm_in;
      tail_lo_ff <= tail_lo_in;
   end

   `SPD_ASSERT(a_body_count_nonzero, (phase_ff == spd_pkg::PH_BODY) |-> (count_ff != 16'd0), "body entered with zero bin count")
   `SPD_ASSERT(a_body_cnt_range, (phase_ff == spd_pkg::PH_BODY) |-> (byte_cnt_ff <= spd_pkg::BIN_LAST_BYTE), "bin byte count out of range")
   `SPD_ASSERT(a_header_cnt_range, (phase_ff == spd_pkg::PH_HEADER) |-> (byte_cnt_ff <= spd_pkg::HEADER_LAST_BYTE), "header byte count out of range")
   `SPD_ASSERT(a_status_restarts, (res_valid && res_data.kind != spd_pkg::KIND_BIN) |=> (phase_ff == spd_pkg::PH_SYNC && elapsed_ff == 16'd0), "status word did not restart sync search")

endmodule

// ===== design/spd_out.sv =====
// ----------------------------------------------------------------------------
// spd_out
// Result register between the framing logic and the rsp word channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spd_out (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  spd_pkg::rsp_type res_data,
   output logic             slot_free,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spd_pkg::rsp_type rsp_data
);

   logic             valid_ff, valid_in;
   spd_pkg::rsp_type data_ff, data_in;

   // a held word leaves in the same cycle a new one is loaded
   assign slot_free = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = res_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   `SPD_ASSERT(a_load_shows, load |=> (rsp_valid && rsp_data == $past(res_data)), "loaded result word not presented")

endmodule

// ===== design/spectrum_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// spectrum_packet_deframer
// Deframes sync-word spectrum packets from a UART byte / tick word stream.
//
//   channel | direction | payload             | handshake
//   req     | in        | spd_pkg::req_type   | req_valid / req_ready
//   rsp     | out       | spd_pkg::rsp_type   | rsp_valid / rsp_ready
//   csr     | in        | index 3b, data 16b  | csr_valid / csr_ready
//
// One req word per cycle while req_ready is high; its result word, if any, shows on rsp the next cycle.
// The framing state is updated from each accepted req word; result words pass through a result register.
// req_ready drops only while a result word is held and rsp_ready is low.
// csr_ready is always high. Synchronous reset restores register defaults and
// sync search; no clearing pass.
// ----------------------------------------------------------------------------
module spectrum_packet_deframer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  spd_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output spd_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [spd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0]                         csr_data
);

   spd_pkg::cfg_type cfg;
   spd_pkg::rsp_type res_data;
   logic             res_valid;
   logic             slot_free;
   logic             fire;

   assign req_ready = slot_free;
   assign fire      = req_valid && slot_free;

   spd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   spd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .req_data  (req_data),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   spd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && res_valid),
      .res_data  (res_data),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
